// ===== design/tgsm_pkg.sv =====
package tgsm_pkg;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_LEAD  = 2'd1,
        PH_TRAIL = 2'd2,
        PH_CLEAR = 2'd3
    } phase_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV1,
        ST_DIV2,
        ST_SUM,
        ST_RLO,
        ST_RHI,
        ST_MUL,
        ST_DIV3,
        ST_OUT
    } calc_state_t;

    // register indexes of the configuration port
    localparam logic [2:0] REG_SPACING = 3'd0;
    localparam logic [2:0] REG_RISE    = 3'd1;
    localparam logic [2:0] REG_FALL    = 3'd2;
    localparam logic [2:0] REG_PINS_A  = 3'd3;
    localparam logic [2:0] REG_PINS_B  = 3'd4;

    // event kinds of a result transaction
    localparam logic [1:0] KIND_LEAD_ON  = 2'd0;
    localparam logic [1:0] KIND_TRAIL_ON = 2'd1;
    localparam logic [1:0] KIND_LEAD_OFF = 2'd2;
    localparam logic [1:0] KIND_DONE     = 2'd3;
    localparam logic [1:0] DIR_NONE  = 2'd0;
    localparam logic [1:0] DIR_AB    = 2'd1;
    localparam logic [1:0] DIR_BA    = 2'd2;

    // divide by five as (x * ceil(2^38 / 5)) >> 38, exact for x below 2^35
    localparam logic [17:0] RECIP5_LO   = 18'h0CCCD;
    localparam logic [17:0] RECIP5_HI   = 18'h33333;
    // 5 * 2^32: at or above this the speed saturates
    localparam logic [63:0] SPEED_SAT_X = 64'h0000_0005_0000_0000;

    // divider request: 64-bit numerator over 64-bit divisor
    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quot;
    } div_rsp_t;

endpackage

// ===== design/tgsm_divider.sv =====
module tgsm_divider
(
    input  logic               clk,
    input  logic               rst_n,
    input  tgsm_pkg::div_req_t req,
    output tgsm_pkg::div_rsp_t rsp
);

    logic [63:0] rem_reg, rem_next;
    logic [63:0] quot_reg, quot_next;
    logic [63:0] den_reg, den_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [64:0] trial;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        rem_next  = rem_reg;
        quot_next = quot_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quot_reg[63]} - {1'b0, den_reg};
        if (req.start)
        begin
            rem_next  = '0;
            quot_next = req.num;
            den_next  = req.den;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[64])
            begin
                rem_next  = trial[63:0];
                quot_next = {quot_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next  = {rem_reg[62:0], quot_reg[63]};
                quot_next = {quot_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        den_reg  <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

// ===== design/two_gate_speed_measure_unit.sv =====
// channel   direction  handshake        payload
// in        input      in_valid/stall   action, pin_bits, pin_level, edge_rising, time_us
// out       output     out_valid/stall  event_kind, direction, speed_m_per_h, ...
// cfg       input      cfg_valid/ready  cfg_index, cfg_data
// An edge that does not close a measurement writes any event it reports to the output
// register, and input is stalled while that register is full and out_stall is high.
// The closing edge starts up to three runs of the shared divider, with sum, reciprocal and
// multiply steps between them, and input is stalled until the result goes out.
// rst_n clears beams, sequencer, counters and configuration to their reset values.
module two_gate_speed_measure_unit
#(
    parameter int PIN_COUNT   = 16,
    parameter int TALLY_WIDTH = 8,
    parameter int TIME_WIDTH  = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [15:0] pin_bits,
    input  logic        pin_level,
    input  logic        edge_rising,
    input  logic [31:0] time_us,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  event_kind,
    output logic [1:0]  direction,
    output logic [31:0] speed_m_per_h,
    output logic signed [31:0] accel_mm_per_s2,
    output logic [31:0] pass_count,
    output logic        calc_error,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int PW = (PIN_COUNT < 16) ? PIN_COUNT : 16;
    localparam int TW = TIME_WIDTH;

    logic [15:0] spacing_reg;
    logic [7:0]  rise_q_reg, fall_q_reg;
    logic [15:0] pins_a_reg, pins_b_reg;

    logic blk_a_reg, blk_b_reg, blk_a_next, blk_b_next;
    logic [TALLY_WIDTH-1:0] tal_a_reg, tal_b_reg, tal_a_next, tal_b_next;
    logic [TW-1:0] rise_a_reg, rise_b_reg, fall_a_reg, fall_b_reg;
    logic [TW-1:0] rise_a_next, rise_b_next, fall_a_next, fall_b_next;
    logic [TW-1:0] cap0_reg, cap1_reg, cap2_reg, cap3_reg;
    logic [TW-1:0] cap0_next, cap1_next, cap2_next, cap3_next;
    tgsm_pkg::phase_t phase_reg, phase_next;
    logic b_leads_reg, b_leads_next;
    logic [1:0] dir_reg, dir_next;
    logic [31:0] passes_reg, passes_next;

    logic        ov_reg;
    logic [1:0]  o_kind_reg, o_dir_reg;
    logic [31:0] o_speed_reg, o_accel_reg, o_pass_reg;
    logic        o_err_reg;

    tgsm_pkg::calc_state_t cst_reg, cst_next;
    logic [63:0] v1_reg, v1_next, v2_reg, v2_next, mul_reg, mul_next;
    logic [63:0] prod_reg, prod_next;
    logic [31:0] spd_reg, spd_next;
    logic [TW-1:0] i1_reg, i1_next, i2_reg, i2_next, i3_reg, i3_next;
    tgsm_pkg::div_req_t dreq;
    tgsm_pkg::div_rsp_t drsp;

    logic accept, emit, start_calc;
    logic [1:0] kind;
    logic       lead_st, trail_st;
    logic [TW-1:0] t, tmp_i1, tmp_i2, avg;
    logic [63:0] diff, q;
    logic [71:0] recip;
    logic neg;
    logic [31:0] f_speed, f_accel;
    logic f_err, fin;

    tgsm_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    assign in_stall  = (cst_reg != tgsm_pkg::ST_IDLE) || (ov_reg && out_stall);
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign t = TW'(time_us);

    // beam qualification and the four-phase sequencer
    always_comb
    begin
        blk_a_next = blk_a_reg; blk_b_next = blk_b_reg;
        tal_a_next = tal_a_reg; tal_b_next = tal_b_reg;
        rise_a_next = rise_a_reg; rise_b_next = rise_b_reg;
        fall_a_next = fall_a_reg; fall_b_next = fall_b_reg;
        cap0_next = cap0_reg; cap1_next = cap1_reg;
        cap2_next = cap2_reg; cap3_next = cap3_reg;
        phase_next = phase_reg; b_leads_next = b_leads_reg;
        dir_next = dir_reg; passes_next = passes_reg;
        emit = 1'b0; start_calc = 1'b0; kind = '0;
        lead_st = 1'b0; trail_st = 1'b0;
        if (accept)
        begin
            if (action)
            begin
                phase_next = tgsm_pkg::PH_IDLE; dir_next = tgsm_pkg::DIR_NONE;
                blk_a_next = 1'b0; blk_b_next = 1'b0;
                tal_a_next = '0; tal_b_next = '0;
            end
            else
            begin
                if ((pins_a_reg[PW-1:0] & pin_bits[PW-1:0]) != '0)
                begin
                    if (blk_a_reg && !pin_level && !edge_rising)
                    begin
                        tal_a_next = tal_a_reg + 1'b1;
                        if (32'(tal_a_next) >= 32'(fall_q_reg))
                        begin
                            blk_a_next = 1'b0; tal_a_next = '0; fall_a_next = t;
                        end
                    end
                    else if (!blk_a_reg && pin_level && edge_rising)
                    begin
                        tal_a_next = tal_a_reg + 1'b1;
                        if (32'(tal_a_next) >= 32'(rise_q_reg))
                        begin
                            blk_a_next = 1'b1; tal_a_next = '0; rise_a_next = t;
                        end
                    end
                end
                if ((pins_b_reg[PW-1:0] & pin_bits[PW-1:0]) != '0)
                begin
                    if (blk_b_reg && !pin_level && !edge_rising)
                    begin
                        tal_b_next = tal_b_reg + 1'b1;
                        if (32'(tal_b_next) >= 32'(fall_q_reg))
                        begin
                            blk_b_next = 1'b0; tal_b_next = '0; fall_b_next = t;
                        end
                    end
                    else if (!blk_b_reg && pin_level && edge_rising)
                    begin
                        tal_b_next = tal_b_reg + 1'b1;
                        if (32'(tal_b_next) >= 32'(rise_q_reg))
                        begin
                            blk_b_next = 1'b1; tal_b_next = '0; rise_b_next = t;
                        end
                    end
                end
                lead_st  = b_leads_reg ? blk_b_next : blk_a_next;
                trail_st = b_leads_reg ? blk_a_next : blk_b_next;
                unique case (phase_reg)
                    tgsm_pkg::PH_IDLE:
                    begin
                        if (blk_a_next && blk_b_next)
                        begin
                            blk_a_next = 1'b0; blk_b_next = 1'b0;
                            tal_a_next = '0; tal_b_next = '0;
                        end
                        else if (blk_a_next || blk_b_next)
                        begin
                            b_leads_next = blk_b_next;
                            cap0_next = blk_b_next ? rise_b_next : rise_a_next;
                            phase_next = tgsm_pkg::PH_LEAD;
                            emit = 1'b1; kind = tgsm_pkg::KIND_LEAD_ON;
                        end
                    end
                    tgsm_pkg::PH_LEAD:
                    begin
                        if (trail_st)
                        begin
                            cap1_next = b_leads_reg ? rise_a_next : rise_b_next;
                            phase_next = tgsm_pkg::PH_TRAIL;
                            emit = 1'b1; kind = tgsm_pkg::KIND_TRAIL_ON;
                        end
                    end
                    tgsm_pkg::PH_TRAIL:
                    begin
                        if (!lead_st)
                        begin
                            cap2_next = b_leads_reg ? fall_b_next : fall_a_next;
                            phase_next = tgsm_pkg::PH_CLEAR;
                            emit = 1'b1; kind = tgsm_pkg::KIND_LEAD_OFF;
                        end
                    end
                    tgsm_pkg::PH_CLEAR:
                    begin
                        if (!trail_st)
                        begin
                            cap3_next = b_leads_reg ? fall_a_next : fall_b_next;
                            phase_next = tgsm_pkg::PH_IDLE;
                            dir_next = b_leads_reg ? tgsm_pkg::DIR_BA : tgsm_pkg::DIR_AB;
                            passes_next = passes_reg + 32'd1;
                            start_calc = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // measurement sequencer around the shared divider
    always_comb
    begin
        cst_next = cst_reg;
        v1_next = v1_reg; v2_next = v2_reg; mul_next = mul_reg;
        prod_next = prod_reg; spd_next = spd_reg;
        i1_next = i1_reg; i2_next = i2_reg; i3_next = i3_reg;
        dreq = '0;
        fin = 1'b0; f_speed = '0; f_accel = '0; f_err = 1'b0;
        tmp_i1 = cap1_next - cap0_next;
        tmp_i2 = cap3_next - cap2_next;
        avg = (tmp_i1 >> 1) + (tmp_i2 >> 1) + TW'(tmp_i1[0] & tmp_i2[0]);
        neg  = v2_reg < v1_reg;
        diff = neg ? v1_reg - v2_reg : v2_reg - v1_reg;
        recip = '0;
        q    = drsp.quot;
        unique case (cst_reg)
            tgsm_pkg::ST_IDLE:
            begin
                if (start_calc)
                begin
                    i1_next = tmp_i1; i2_next = tmp_i2;
                    i3_next = (cap2_next - cap1_next) + avg;
                    mul_next = 64'(spacing_reg) * 64'd1000000;
                    cst_next = tgsm_pkg::ST_DIV1;
                    if (tmp_i1 == '0 || tmp_i2 == '0)
                        cst_next = tgsm_pkg::ST_OUT;
                    else
                    begin
                        dreq.start = 1'b1;
                        dreq.num = 64'(spacing_reg) * 64'd1000000;
                        dreq.den = 64'(tmp_i1);
                    end
                end
            end
            tgsm_pkg::ST_DIV1:
            begin
                if (drsp.done)
                begin
                    v1_next = q;
                    dreq.start = 1'b1; dreq.num = mul_reg; dreq.den = 64'(i2_reg);
                    cst_next = tgsm_pkg::ST_DIV2;
                end
            end
            tgsm_pkg::ST_DIV2:
            begin
                if (drsp.done)
                begin
                    v2_next = q;
                    cst_next = tgsm_pkg::ST_SUM;
                end
            end
            tgsm_pkg::ST_SUM:
            begin
                // nine times the velocity sum, divided by five below
                mul_next = (v1_reg + v2_reg) * 64'd9;
                cst_next = tgsm_pkg::ST_RLO;
            end
            tgsm_pkg::ST_RLO:
            begin
                prod_next = {29'd0, mul_reg[34:0]} * {46'd0, tgsm_pkg::RECIP5_LO};
                cst_next = tgsm_pkg::ST_RHI;
            end
            tgsm_pkg::ST_RHI:
            begin
                recip = (({37'd0, mul_reg[34:0]} * {54'd0, tgsm_pkg::RECIP5_HI}) << 18)
                        + {8'd0, prod_reg};
                spd_next = (mul_reg >= tgsm_pkg::SPEED_SAT_X) ? 32'hFFFF_FFFF : recip[69:38];
                cst_next = tgsm_pkg::ST_MUL;
            end
            tgsm_pkg::ST_MUL:
            begin
                // diff fits 36 bits, so diff*1e6 stays within 64 bits
                mul_next = diff * 64'd1000000;
                cst_next = tgsm_pkg::ST_DIV3;
                if (i3_reg != '0)
                begin
                    dreq.start = 1'b1;
                    dreq.num = diff * 64'd1000000;
                    dreq.den = 64'(i3_reg);
                end
                else
                    cst_next = tgsm_pkg::ST_OUT;
            end
            tgsm_pkg::ST_DIV3:
            begin
                if (drsp.done)
                    cst_next = tgsm_pkg::ST_OUT;
            end
            tgsm_pkg::ST_OUT:
            begin
                if (!(ov_reg && out_stall))
                begin
                    fin = 1'b1;
                    cst_next = tgsm_pkg::ST_IDLE;
                    if (i1_reg == '0 || i2_reg == '0)
                    begin
                        f_err = 1'b1; f_speed = 32'hFFFF_FFFF;
                        if (i1_reg == '0 && i2_reg == '0) f_accel = '0;
                        else if (i1_reg == '0) f_accel = 32'h8000_0000;
                        else f_accel = 32'h7FFF_FFFF;
                    end
                    else
                    begin
                        f_speed = spd_reg;
                        if (i3_reg == '0)
                        begin
                            f_err = 1'b1;
                            f_accel = (diff == '0) ? 32'd0 :
                                      (neg ? 32'h8000_0000 : 32'h7FFF_FFFF);
                        end
                        else if (neg)
                            f_accel = (q >= 64'h8000_0000) ? 32'h8000_0000 : 32'd0 - q[31:0];
                        else
                            f_accel = (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
                    end
                end
            end
            default: cst_next = tgsm_pkg::ST_IDLE;
        endcase
    end

    // configuration and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spacing_reg <= 16'd540; rise_q_reg <= 8'd1; fall_q_reg <= 8'd1;
            pins_a_reg <= 16'h00FF; pins_b_reg <= 16'hFF00;
            blk_a_reg <= 1'b0; blk_b_reg <= 1'b0; tal_a_reg <= '0; tal_b_reg <= '0;
            rise_a_reg <= '0; rise_b_reg <= '0; fall_a_reg <= '0; fall_b_reg <= '0;
            cap0_reg <= '0; cap1_reg <= '0; cap2_reg <= '0; cap3_reg <= '0;
            phase_reg <= tgsm_pkg::PH_IDLE; b_leads_reg <= 1'b0;
            dir_reg <= tgsm_pkg::DIR_NONE; passes_reg <= '0;
            cst_reg <= tgsm_pkg::ST_IDLE; ov_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    tgsm_pkg::REG_SPACING: spacing_reg <= cfg_data;
                    tgsm_pkg::REG_RISE:    rise_q_reg  <= cfg_data[7:0];
                    tgsm_pkg::REG_FALL:    fall_q_reg  <= cfg_data[7:0];
                    tgsm_pkg::REG_PINS_A:  pins_a_reg  <= cfg_data;
                    tgsm_pkg::REG_PINS_B:  pins_b_reg  <= cfg_data;
                    default: ;
                endcase
            end
            blk_a_reg <= blk_a_next; blk_b_reg <= blk_b_next;
            tal_a_reg <= tal_a_next; tal_b_reg <= tal_b_next;
            rise_a_reg <= rise_a_next; rise_b_reg <= rise_b_next;
            fall_a_reg <= fall_a_next; fall_b_reg <= fall_b_next;
            cap0_reg <= cap0_next; cap1_reg <= cap1_next;
            cap2_reg <= cap2_next; cap3_reg <= cap3_next;
            phase_reg <= phase_next; b_leads_reg <= b_leads_next;
            dir_reg <= dir_next; passes_reg <= passes_next;
            cst_reg <= cst_next;
            if (emit || fin) ov_reg <= 1'b1;
            else if (!out_stall) ov_reg <= 1'b0;
        end
    end

    // measurement data and output register
    always_ff @(posedge clk)
    begin
        v1_reg <= v1_next; v2_reg <= v2_next; mul_reg <= mul_next;
        prod_reg <= prod_next; spd_reg <= spd_next;
        i1_reg <= i1_next; i2_reg <= i2_next; i3_reg <= i3_next;
        if (emit)
        begin
            o_kind_reg <= kind; o_dir_reg <= dir_next;
            o_speed_reg <= '0; o_accel_reg <= '0; o_err_reg <= 1'b0;
            o_pass_reg <= passes_next;
        end
        else if (fin)
        begin
            o_kind_reg <= tgsm_pkg::KIND_DONE; o_dir_reg <= dir_reg;
            o_speed_reg <= f_speed; o_accel_reg <= f_accel; o_err_reg <= f_err;
            o_pass_reg <= passes_reg;
        end
    end

    assign out_valid       = ov_reg;
    assign event_kind      = o_kind_reg;
    assign direction       = o_dir_reg;
    assign speed_m_per_h   = o_speed_reg;
    assign accel_mm_per_s2 = o_accel_reg;
    assign pass_count      = o_pass_reg;
    assign calc_error      = o_err_reg;

endmodule

// ===== sim/tgsm_speed_checker.sv =====
module tgsm_speed_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        action,
    input  logic [15:0] pin_bits,
    input  logic        pin_level,
    input  logic        edge_rising,
    input  logic [31:0] time_us,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  event_kind,
    input  logic [1:0]  direction,
    input  logic [31:0] speed_m_per_h,
    input  logic signed [31:0] accel_mm_per_s2,
    input  logic [31:0] pass_count,
    input  logic        calc_error,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  dir;
        logic [31:0] speed;
        logic [31:0] accel;
        logic [31:0] count;
        logic        err;
    } gate_report_t;

    gate_report_t expected_reports[$];

    // shadow configuration
    logic [15:0] spacing;
    logic [7:0]  rise_need;
    logic [7:0]  fall_need;
    logic [15:0] pins_a;
    logic [15:0] pins_b;

    // shadow beam and sequencer state, index 0 is sensor a
    logic        blocked [2];
    logic [7:0]  tally [2];
    logic [31:0] rise_t [2];
    logic [31:0] fall_t [2];
    tgsm_pkg::phase_t seq_phase;
    logic        b_lead;
    logic [31:0] cap [4];
    logic [1:0]  last_dir;
    logic [31:0] passes;

    // count one edge against a beam and flip its state when qualified
    task automatic qualify_beam(input int idx, input logic [15:0] pins,
                                input logic [15:0] bits, input logic lvl,
                                input logic rise, input logic [31:0] t);
        if ((pins & bits) == 16'h0)
            return;
        if (blocked[idx])
        begin
            if (!lvl && !rise)
            begin
                tally[idx] = tally[idx] + 8'd1;
                if (tally[idx] >= fall_need)
                begin
                    blocked[idx] = 1'b0;
                    tally[idx]   = 8'd0;
                    fall_t[idx]  = t;
                end
            end
        end
        else
        begin
            if (lvl && rise)
            begin
                tally[idx] = tally[idx] + 8'd1;
                if (tally[idx] >= rise_need)
                begin
                    blocked[idx] = 1'b1;
                    tally[idx]   = 8'd0;
                    rise_t[idx]  = t;
                end
            end
        end
    endtask

    task automatic clear_both();
        blocked[0] = 1'b0;
        blocked[1] = 1'b0;
        tally[0]   = 8'd0;
        tally[1]   = 8'd0;
    endtask

    // speed and acceleration from the four captured times
    task automatic measure_speed(inout gate_report_t rep);
        logic [63:0] i1, i2, avg, i3, num, v1, v2, diff, spd, q;
        logic [31:0] acc;
        logic        neg;
        i1  = {32'h0, cap[1] - cap[0]};
        i2  = {32'h0, cap[3] - cap[2]};
        avg = (i1 >> 1) + (i2 >> 1) + (i1 & i2 & 64'd1);
        i3  = {32'h0, (cap[2] - cap[1]) + avg[31:0]};
        num = {48'h0, spacing} * 64'd1000000;
        rep.err = 1'b0;
        if (i1 == 64'd0 || i2 == 64'd0)
        begin
            rep.err = 1'b1;
            spd = 64'hFFFF_FFFF;
            if (i1 == 64'd0 && i2 == 64'd0)
                acc = 32'h0;
            else if (i1 == 64'd0)
                acc = 32'h8000_0000;
            else
                acc = 32'h7FFF_FFFF;
        end
        else
        begin
            v1   = num / i1;
            v2   = num / i2;
            neg  = v2 < v1;
            diff = neg ? v1 - v2 : v2 - v1;
            spd  = (v1 + v2) * 64'd9 / 64'd5;
            if (spd > 64'hFFFF_FFFF)
                spd = 64'hFFFF_FFFF;
            if (i3 == 64'd0)
            begin
                rep.err = 1'b1;
                acc = (diff == 64'd0) ? 32'h0 : (neg ? 32'h8000_0000 : 32'h7FFF_FFFF);
            end
            else
            begin
                q = diff * 64'd1000000 / i3;
                if (neg)
                    acc = (q >= 64'h8000_0000) ? 32'h8000_0000 : 32'h0 - q[31:0];
                else
                    acc = (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
            end
        end
        rep.speed = spd[31:0];
        rep.accel = acc;
    endtask

    // advance the shadow sequencer by one input transaction
    task automatic predict_edge();
        gate_report_t rep;
        int kind;
        int lead;
        int trail;
        kind = -1;
        rep  = '0;
        if (action)
        begin
            seq_phase = tgsm_pkg::PH_IDLE;
            last_dir  = tgsm_pkg::DIR_NONE;
            clear_both();
            return;
        end
        qualify_beam(0, pins_a, pin_bits, pin_level, edge_rising, time_us);
        qualify_beam(1, pins_b, pin_bits, pin_level, edge_rising, time_us);
        lead  = b_lead ? 1 : 0;
        trail = 1 - lead;
        case (seq_phase)
            tgsm_pkg::PH_IDLE:
            begin
                if (blocked[0] && blocked[1])
                    clear_both();
                else if (blocked[0] || blocked[1])
                begin
                    b_lead    = blocked[1];
                    cap[0]    = rise_t[blocked[1] ? 1 : 0];
                    seq_phase = tgsm_pkg::PH_LEAD;
                    kind      = int'(tgsm_pkg::KIND_LEAD_ON);
                end
            end
            tgsm_pkg::PH_LEAD:
            begin
                if (blocked[trail])
                begin
                    cap[1]    = rise_t[trail];
                    seq_phase = tgsm_pkg::PH_TRAIL;
                    kind      = int'(tgsm_pkg::KIND_TRAIL_ON);
                end
            end
            tgsm_pkg::PH_TRAIL:
            begin
                if (!blocked[lead])
                begin
                    cap[2]    = fall_t[lead];
                    seq_phase = tgsm_pkg::PH_CLEAR;
                    kind      = int'(tgsm_pkg::KIND_LEAD_OFF);
                end
            end
            default:
            begin
                if (!blocked[trail])
                begin
                    cap[3]    = fall_t[trail];
                    seq_phase = tgsm_pkg::PH_IDLE;
                    last_dir  = b_lead ? tgsm_pkg::DIR_BA : tgsm_pkg::DIR_AB;
                    passes    = passes + 32'd1;
                    kind      = int'(tgsm_pkg::KIND_DONE);
                end
            end
        endcase
        if (kind < 0)
            return;
        rep.kind = kind[1:0];
        rep.dir  = last_dir;
        if (rep.kind == tgsm_pkg::KIND_DONE)
            measure_speed(rep);
        rep.count = passes;
        expected_reports.push_back(rep);
    endtask

    task automatic compare_report();
        gate_report_t exp_rep;
        if (expected_reports.size() == 0)
        begin
            fail_count = fail_count + 1;
            $display("%0t: unexpected result transaction kind %0d", $time, event_kind);
            return;
        end
        exp_rep = expected_reports.pop_front();
        if (event_kind !== exp_rep.kind)
        begin
            fail_count = fail_count + 1;
            $display("%0t: event_kind expected %0d actual %0d", $time, exp_rep.kind, event_kind);
        end
        if (direction !== exp_rep.dir)
        begin
            fail_count = fail_count + 1;
            $display("%0t: direction expected %0d actual %0d", $time, exp_rep.dir, direction);
        end
        if (speed_m_per_h !== exp_rep.speed)
        begin
            fail_count = fail_count + 1;
            $display("%0t: speed_m_per_h expected %0d actual %0d", $time, exp_rep.speed,
                     speed_m_per_h);
        end
        if (accel_mm_per_s2 !== exp_rep.accel)
        begin
            fail_count = fail_count + 1;
            $display("%0t: accel_mm_per_s2 expected %0d actual %0d", $time,
                     $signed(exp_rep.accel), accel_mm_per_s2);
        end
        if (pass_count !== exp_rep.count)
        begin
            fail_count = fail_count + 1;
            $display("%0t: pass_count expected %0d actual %0d", $time, exp_rep.count, pass_count);
        end
        if (calc_error !== exp_rep.err)
        begin
            fail_count = fail_count + 1;
            $display("%0t: calc_error expected %0d actual %0d", $time, exp_rep.err, calc_error);
        end
    endtask

    initial
    begin
        fail_count = 0;
    end

    // observe configuration, input and result transactions
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spacing   = 16'd540;
            rise_need = 8'd1;
            fall_need = 8'd1;
            pins_a    = 16'h00FF;
            pins_b    = 16'hFF00;
            clear_both();
            rise_t[0] = 32'h0;
            rise_t[1] = 32'h0;
            fall_t[0] = 32'h0;
            fall_t[1] = 32'h0;
            seq_phase = tgsm_pkg::PH_IDLE;
            b_lead    = 1'b0;
            for (int i = 0; i < 4; i++)
                cap[i] = 32'h0;
            last_dir  = tgsm_pkg::DIR_NONE;
            passes    = 32'h0;
            expected_reports.delete();
            pending   <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    tgsm_pkg::REG_SPACING: spacing   = cfg_data;
                    tgsm_pkg::REG_RISE:    rise_need = cfg_data[7:0];
                    tgsm_pkg::REG_FALL:    fall_need = cfg_data[7:0];
                    tgsm_pkg::REG_PINS_A:  pins_a    = cfg_data;
                    tgsm_pkg::REG_PINS_B:  pins_b    = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
                compare_report();
            if (in_valid && !in_stall)
                predict_edge();
            pending <= expected_reports.size();
        end
    end

endmodule

// ===== sim/tb_two_gate_speed_measure_unit.sv =====
module tb_two_gate_speed_measure_unit;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 250;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        action;
    logic [15:0] pin_bits;
    logic        pin_level;
    logic        edge_rising;
    logic [31:0] time_us;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  event_kind;
    logic [1:0]  direction;
    logic [31:0] speed_m_per_h;
    logic signed [31:0] accel_mm_per_s2;
    logic [31:0] pass_count;
    logic        calc_error;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    int fail_count;
    int pending;
    int tx_gap;
    int rx_gap;
    int quiet_cycles;
    int edges_sent;

    // local copy of what was written, used to shape well-formed passes
    logic [15:0] cur_pins_a;
    logic [15:0] cur_pins_b;
    int          cur_rise;
    int          cur_fall;

    two_gate_speed_measure_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .pin_bits(pin_bits), .pin_level(pin_level),
        .edge_rising(edge_rising), .time_us(time_us),
        .out_valid(out_valid), .out_stall(out_stall),
        .event_kind(event_kind), .direction(direction),
        .speed_m_per_h(speed_m_per_h), .accel_mm_per_s2(accel_mm_per_s2),
        .pass_count(pass_count), .calc_error(calc_error),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    tgsm_speed_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .pin_bits(pin_bits), .pin_level(pin_level),
        .edge_rising(edge_rising), .time_us(time_us),
        .out_valid(out_valid), .out_stall(out_stall),
        .event_kind(event_kind), .direction(direction),
        .speed_m_per_h(speed_m_per_h), .accel_mm_per_s2(accel_mm_per_s2),
        .pass_count(pass_count), .calc_error(calc_error),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver stall
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < rx_gap);
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("two_gate_speed_measure_unit regression: fail");
                $finish;
            end
        end
    end

    task automatic send_edge(input logic act, input logic [15:0] bits, input logic lvl,
                             input logic rise, input logic [31:0] t);
        logic seen_stall;
        while ($urandom_range(99) < tx_gap)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        action      <= act;
        pin_bits    <= bits;
        pin_level   <= lvl;
        edge_rising <= rise;
        time_us     <= t;
        do
        begin
            @(negedge clk);
            seen_stall = in_stall;
            @(posedge clk);
        end
        while (seen_stall);
        edges_sent++;
    endtask

    // hold input until all results are out and the divider has settled
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        logic seen_ready;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
        begin
            @(negedge clk);
            seen_ready = cfg_ready;
            @(posedge clk);
        end
        while (!seen_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_setting(input logic [15:0] spc, input int rise, input int fall,
                                 input logic [15:0] pa, input logic [15:0] pb);
        drain();
        write_reg(tgsm_pkg::REG_SPACING, spc);
        write_reg(tgsm_pkg::REG_RISE, rise[15:0]);
        write_reg(tgsm_pkg::REG_FALL, fall[15:0]);
        write_reg(tgsm_pkg::REG_PINS_A, pa);
        write_reg(tgsm_pkg::REG_PINS_B, pb);
        cur_rise   = rise;
        cur_fall   = fall;
        cur_pins_a = pa;
        cur_pins_b = pb;
    endtask

    // one-hot pin of a sensor, preferring pins the other sensor does not share
    function automatic logic [15:0] pick_pin(input logic [15:0] mask, input logic [15:0] other);
        logic [15:0] pool;
        int idx;
        pool = mask & ~other;
        if (pool == 16'h0)
            pool = mask;
        if (pool == 16'h0)
            return 16'h0001;
        idx = $urandom_range(15);
        while (!pool[idx])
            idx = $urandom_range(15);
        return 16'h0001 << idx;
    endfunction

    // lead block, trail block, lead clear, trail clear; stops early after 'stages'
    task automatic run_pass(input logic lead_b, input logic [31:0] t0, input logic [31:0] t1,
                            input logic [31:0] t2, input logic [31:0] t3, input int stages);
        logic [15:0] lp;
        logic [15:0] tp;
        lp = lead_b ? pick_pin(cur_pins_b, cur_pins_a) : pick_pin(cur_pins_a, cur_pins_b);
        tp = lead_b ? pick_pin(cur_pins_a, cur_pins_b) : pick_pin(cur_pins_b, cur_pins_a);
        repeat (cur_rise) send_edge(1'b0, lp, 1'b1, 1'b1, t0);
        if (stages < 2)
            return;
        repeat (cur_rise) send_edge(1'b0, tp, 1'b1, 1'b1, t1);
        if (stages < 3)
            return;
        repeat (cur_fall) send_edge(1'b0, lp, 1'b0, 1'b0, t2);
        if (stages < 4)
            return;
        repeat (cur_fall) send_edge(1'b0, tp, 1'b0, 1'b0, t3);
    endtask

    task automatic noise_edge();
        logic [15:0] bits;
        bits = ($urandom_range(1) == 0) ? 16'($urandom()) : (16'h0001 << $urandom_range(15));
        send_edge($urandom_range(9) == 0, bits, 1'($urandom_range(1)),
                  1'($urandom_range(1)), $urandom());
    endtask

    function automatic logic [31:0] gap_us();
        case ($urandom_range(11))
            0:       return 32'h0;
            1:       return $urandom();
            2:       return $urandom_range(1, 3);
            default: return $urandom_range(1, 60000);
        endcase
    endfunction

    task automatic random_traffic(input int count);
        int target;
        int stages;
        logic [31:0] t0, t1, t2, t3;
        target = edges_sent + count;
        while (edges_sent < target)
        begin
            if ($urandom_range(9) < 2)
                noise_edge();
            else
            begin
                t0 = $urandom();
                t1 = t0 + gap_us();
                t2 = t1 + gap_us();
                t3 = t2 + gap_us();
                stages = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : 4;
                run_pass(1'($urandom_range(1)), t0, t1, t2, t3, stages);
                if (stages < 4 && $urandom_range(1) == 0)
                    send_edge(1'b1, 16'($urandom()), 1'($urandom_range(1)),
                              1'($urandom_range(1)), $urandom());
            end
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        action      = 1'b0;
        pin_bits    = 16'h0;
        pin_level   = 1'b0;
        edge_rising = 1'b0;
        time_us     = 32'h0;
        out_stall   = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = tgsm_pkg::REG_SPACING;
        cfg_data    = 16'h0;
        quiet_cycles = 0;
        edges_sent  = 0;
        tx_gap      = 23;
        rx_gap      = 88;
        cur_pins_a  = 16'h00FF;
        cur_pins_b  = 16'hFF00;
        cur_rise    = 1;
        cur_fall    = 1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: unqualified edges, both directions, wrap and zero intervals
        send_edge(1'b0, 16'h0001, 1'b0, 1'b1, 32'd10);
        send_edge(1'b0, 16'h0100, 1'b1, 1'b0, 32'd20);
        run_pass(1'b0, 32'd1000, 32'd1500, 32'd3000, 32'd3600, 4);
        run_pass(1'b1, 32'hFFFF_FF00, 32'h0000_0100, 32'h0000_0400, 32'hFFFF_FFFF, 4);
        run_pass(1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 4);
        run_pass(1'b1, 32'd500, 32'd500, 32'd900, 32'd1000, 4);
        run_pass(1'b0, 32'd500, 32'd700, 32'd900, 32'd900, 4);
        // acceleration interval wraps to zero
        run_pass(1'b0, 32'd0, 32'd100, 32'd25, 32'd75, 4);
        run_pass(1'b1, 32'd10, 32'd20, 32'd30, 32'd40, 2);
        send_edge(1'b1, 16'h0, 1'b0, 1'b0, 32'd50);
        // an edge on every pin blocks both beams while idle
        send_edge(1'b0, 16'hFFFF, 1'b1, 1'b1, 32'd60);
        drain();
        random_traffic(100);

        tx_gap = 88;
        rx_gap = 23;
        apply_setting(16'd65535, 2, 3, 16'h000F, 16'hF000);
        random_traffic(120);
        apply_setting(16'd1, 1, 1, 16'h0000, 16'hFFFF);
        random_traffic(20);

        tx_gap = 0;
        rx_gap = 0;
        apply_setting(16'd1, 6, 5, 16'h0001, 16'h8000);
        run_pass(1'b1, 32'd100, 32'd300, 32'd700, 32'd800, 4);
        apply_setting(16'd1234, 1, 2, 16'h0FF0, 16'hFF00);
        send_edge(1'b0, 16'h0800, 1'b1, 1'b1, 32'd5);
        random_traffic(120);
        apply_setting(16'd540, 1, 1, 16'h00FF, 16'hFF00);
        random_traffic(60);

        drain();
        if (fail_count == 0)
            $display("two_gate_speed_measure_unit regression: pass");
        else
            $display("two_gate_speed_measure_unit regression: fail");
        $finish;
    end

endmodule
